### rtl/core/square_wave_pattern_synth_assert.svh
// Assertion macros for the square-wave pattern synth.
// Used by the top level; expands to nothing when SYNTHESIS is defined.
`ifndef SQUARE_WAVE_PATTERN_SYNTH_ASSERT_SVH
`define SQUARE_WAVE_PATTERN_SYNTH_ASSERT_SVH
`ifndef SYNTHESIS
`define SWPS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define SWPS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SWPS_ASSERT(lbl, clk, rstn, prop, msg)
`define SWPS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

### rtl/core/swps_pkg.sv
// Types, constants and note tables for the square-wave pattern synth.
// No dependencies.
package swps_pkg;

  localparam int MUL_A_W = 22;
  localparam int MUL_B_W = 32;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  localparam logic [21:0] WRAP_SAMPLES   = 22'd2646000;
  localparam logic [13:0] EIGHTH_SAMPLES = 14'd11025;
  localparam logic [13:0] HAT_WINDOW     = 14'd2757;
  localparam logic [9:0]  HAT_MOD        = 10'd441;
  localparam logic [9:0]  HAT_STEP       = 10'd80;
  localparam logic [8:0]  HAT_MID        = 9'd221;
  localparam logic [31:0] AMP_HAT        = 32'd2621;
  localparam logic [31:0] HAT_RECIP      = 32'd2434789;  // ceil(2^30 / 441)
  localparam int          HAT_SHIFT      = 30;

  localparam logic signed [16:0] AMP_MELODY = 17'sd8192;
  localparam logic signed [16:0] AMP_BASS   = 17'sd6553;
  localparam logic signed [16:0] CLIP_LEVEL = 17'sd29490;

  localparam logic [8:0] VOL_MAX   = 9'd256;
  localparam logic [8:0] VOL_RESET = 9'd102;

  typedef enum logic [0:0] {
    REG_VOLUME = 1'b0,
    REG_ENABLE = 1'b1
  } reg_idx_e;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_MEL  = 7'b0000010,
    S_BAS  = 7'b0000100,
    S_HAT1 = 7'b0001000,
    S_HAT2 = 7'b0010000,
    S_MIX  = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_e;

  localparam logic [31:0] MELODY_INC [16] = '{
    32'd42852281, 32'd42852281, 32'd50960128, 32'd48099738,
    32'd42852281, 32'd42852281, 32'd64205378, 32'd57200978,
    32'd42852281, 32'd42852281, 32'd50960128, 32'd48099738,
    32'd42852281, 32'd64205378, 32'd57200978, 32'd50960128
  };

  localparam logic [31:0] BASS_INC [8] = '{
    32'd10713070, 32'd10713070, 32'd8026038, 32'd8026038,
    32'd9544372,  32'd9544372,  32'd8026038, 32'd8026038
  };

endpackage

### rtl/core/swps_req_if.sv
// Request channel: one transfer asks for a burst of samples.
// Depends on nothing.
interface swps_req_if;
  logic       valid;
  logic       ready;
  logic [6:0] sample_count;

  modport source (output valid, output sample_count, input ready);
  modport sink   (input valid, input sample_count, output ready);
endinterface

### rtl/core/swps_pcm_if.sv
// Sample channel: one transfer carries one PCM sample.
// Depends on nothing.
interface swps_pcm_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] pcm_sample;
  logic               last;

  modport source (output valid, output pcm_sample, output last, input ready);
  modport sink   (input valid, input pcm_sample, input last, output ready);
endinterface

### rtl/core/swps_mul.sv
// Shared unsigned multiplier with registered product.
// Depends on swps_pkg.
module swps_mul (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [swps_pkg::MUL_A_W-1:0]  a_i,
  input  logic [swps_pkg::MUL_B_W-1:0]  b_i,
  output logic [swps_pkg::MUL_P_W-1:0]  p_o
);
  import swps_pkg::*;

  logic [MUL_P_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= MUL_P_W'(a_i) * MUL_P_W'(b_i);
    end
  end

  assign p_o = p_q;
endmodule

### rtl/core/square_wave_pattern_synth.sv
// Square-wave pattern synth: bursts of PCM samples from a stored sample counter.
// Each sample steps through states MEL, BAS, HAT1, HAT2, MIX and OUT, and the
// shared multiplier does five products per sample. OUT loads the output register;
// the request side stays busy, output stalls included, until the burst is done.
// Reset: counter at zero, volume 102, disabled. No clearing pass.
// Depends on swps_pkg, swps_req_if, swps_pcm_if, swps_mul and the assert header.
`include "square_wave_pattern_synth_assert.svh"
module square_wave_pattern_synth #(
  parameter int MAX_BURST = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  swps_req_if.sink    req_i,
  swps_pcm_if.source  pcm_o,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [8:0]  cfg_wdata_i
);
  import swps_pkg::*;

  localparam int CntW = $clog2(MAX_BURST + 1);

  state_e              state_q, state_d;
  logic [21:0]         t_q;
  logic [13:0]         pos_q;
  logic [3:0]          eig_q;
  logic [8:0]          r_q;
  logic [CntW-1:0]     rem_q;
  logic [8:0]          vol_q;
  logic                en_q;
  logic                mel_neg_q, bas_neg_q, sgn_q;
  logic                out_valid_q, out_last_q;
  logic signed [15:0]  out_pcm_q;

  logic [MUL_A_W-1:0]  mul_a;
  logic [MUL_B_W-1:0]  mul_b;
  logic [MUL_P_W-1:0]  prod;
  logic                mul_en;

  logic [CntW-1:0]     n_eff;
  logic                in_xfer, advance;
  logic                hat_on, hat_neg;
  logic [8:0]          hat_arg;
  logic [11:0]         hat_mag;
  logic signed [16:0]  mel_val, bas_val, hat_val, sum, clip;
  logic [14:0]         sum_mag, out_mag;
  logic [9:0]          r_inc;

  swps_mul u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  assign req_i.ready     = (state_q == S_IDLE);
  assign in_xfer         = req_i.valid && req_i.ready;
  assign advance         = !out_valid_q || pcm_o.ready;
  assign pcm_o.valid     = out_valid_q;
  assign pcm_o.pcm_sample = out_pcm_q;
  assign pcm_o.last      = out_last_q;

  always_comb begin
    if (32'(req_i.sample_count) > MAX_BURST) begin
      n_eff = CntW'(MAX_BURST);
    end else begin
      n_eff = CntW'(req_i.sample_count);
    end
  end

  assign hat_on  = pos_q < HAT_WINDOW;
  assign hat_neg = r_q < HAT_MID;
  assign hat_arg = hat_neg ? 9'(HAT_MOD - {r_q, 1'b0}) : 9'({r_q, 1'b0} - HAT_MOD);
  assign hat_mag = prod[HAT_SHIFT +: 12];

  assign mel_val = mel_neg_q ? -AMP_MELODY : AMP_MELODY;
  assign bas_val = bas_neg_q ? -AMP_BASS : AMP_BASS;
  assign hat_val = !hat_on ? 17'sd0 :
                   hat_neg ? -$signed({5'b0, hat_mag}) : $signed({5'b0, hat_mag});
  assign sum     = mel_val + bas_val + hat_val;

  always_comb begin
    if (sum > CLIP_LEVEL) begin
      clip = CLIP_LEVEL;
    end else if (sum < -CLIP_LEVEL) begin
      clip = -CLIP_LEVEL;
    end else begin
      clip = sum;
    end
  end

  assign sum_mag = clip[16] ? 15'(-clip) : 15'(clip);
  assign out_mag = prod[22:8];
  assign r_inc   = {1'b0, r_q} + HAT_STEP;

  always_comb begin
    mul_en = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    case (state_q)
      S_MEL: begin
        mul_a = t_q;
        mul_b = MELODY_INC[eig_q];
      end
      S_BAS: begin
        mul_a = t_q;
        mul_b = BASS_INC[eig_q[3:1]];
      end
      S_HAT1: begin
        mul_a = MUL_A_W'(hat_arg);
        mul_b = AMP_HAT;
      end
      S_HAT2: begin
        mul_a = prod[MUL_A_W-1:0];
        mul_b = HAT_RECIP;
      end
      S_MIX: begin
        mul_a = MUL_A_W'(sum_mag);
        mul_b = MUL_B_W'(vol_q);
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_xfer && en_q && (req_i.sample_count != '0)) begin
          state_d = S_MEL;
        end
      end
      S_MEL:  state_d = S_BAS;
      S_BAS:  state_d = S_HAT1;
      S_HAT1: state_d = S_HAT2;
      S_HAT2: state_d = S_MIX;
      S_MIX:  state_d = S_OUT;
      S_OUT: begin
        if (advance) begin
          state_d = (rem_q == CntW'(1)) ? S_IDLE : S_MEL;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      t_q         <= '0;
      pos_q       <= '0;
      eig_q       <= '0;
      r_q         <= '0;
      rem_q       <= '0;
      vol_q       <= VOL_RESET;
      en_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_VOLUME: vol_q <= (cfg_wdata_i > VOL_MAX) ? VOL_MAX : cfg_wdata_i;
          REG_ENABLE: en_q  <= cfg_wdata_i[0];
          default: ;
        endcase
      end
      if (state_q == S_IDLE && in_xfer) begin
        rem_q <= n_eff;
      end
      if (pcm_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == S_OUT && advance) begin
        out_valid_q <= 1'b1;
        rem_q       <= rem_q - CntW'(1);
        t_q         <= (t_q == WRAP_SAMPLES - 22'd1) ? '0 : t_q + 22'd1;
        pos_q       <= (pos_q == EIGHTH_SAMPLES - 14'd1) ? '0 : pos_q + 14'd1;
        if (pos_q == EIGHTH_SAMPLES - 14'd1) begin
          eig_q <= eig_q + 4'd1;
        end
        r_q <= (r_inc >= HAT_MOD) ? 9'(r_inc - HAT_MOD) : r_inc[8:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_BAS: mel_neg_q <= prod[31];
      S_HAT1: bas_neg_q <= prod[31];
      S_MIX: sgn_q <= clip[16];
      S_OUT: begin
        if (advance) begin
          out_pcm_q  <= sgn_q ? -$signed({1'b0, out_mag}) : $signed({1'b0, out_mag});
          out_last_q <= (rem_q == CntW'(1));
        end
      end
      default: ;
    endcase
  end

  `SWPS_ASSERT(a_time_range, clk_i, rst_ni, t_q < WRAP_SAMPLES, "sample counter out of range")
  `SWPS_ASSERT(a_sub_range, clk_i, rst_ni, (pos_q < EIGHTH_SAMPLES) && (r_q < 9'(HAT_MOD)), "note position or hat residue out of range")
  `SWPS_ASSERT(a_busy_count, clk_i, rst_ni, (state_q != S_IDLE) |-> (rem_q != '0), "busy with empty burst")
  `SWPS_ASSERT(a_start_busy, clk_i, rst_ni, (in_xfer && en_q && (req_i.sample_count != '0)) |=> !req_i.ready, "burst did not start")

endmodule

### tb/sv/testbench.sv
// Self-checking testbench for square_wave_pattern_synth: drives burst requests and register
// writes, and compares every PCM transfer against an in-bench prediction of the synth.
// Depends on swps_pkg, swps_req_if, swps_pcm_if and the square_wave_pattern_synth RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import swps_pkg::*;

  localparam int          BURST_LIMIT     = 64;
  localparam int unsigned QUARTER_SAMPLES = 2 * EIGHTH_SAMPLES;
  localparam int          SETTLE_CYCLES   = 24;
  localparam int          CYCLE_LIMIT     = 2_000_000;
  localparam int          PHASE_ITEMS     = 70;

  typedef struct packed {
    logic signed [15:0] pcm_sample;
    logic               last;
  } pcm_beat_t;

  class pcm_scoreboard;
    int unsigned sample_time;
    logic [8:0]  volume;
    bit          enabled;
    pcm_beat_t   expected_q[$];
    int          errors;

    function new();
      sample_time = 0;
      volume      = VOL_RESET;
      enabled     = 1'b0;
      errors      = 0;
    endfunction

    function void configure(reg_idx_e idx, logic [8:0] data);
      case (idx)
        REG_VOLUME: volume = (data > VOL_MAX) ? VOL_MAX : data;
        REG_ENABLE: enabled = data[0];
        default: ;
      endcase
    endfunction

    function logic signed [15:0] synth(int unsigned t);
      int unsigned eighth, quarter;
      logic [31:0] phase;
      int          mix, r, clip;
      eighth  = (t / EIGHTH_SAMPLES) % 16;
      quarter = (t / QUARTER_SAMPLES) % 8;
      phase   = 32'(64'(t) * 64'(MELODY_INC[eighth]));
      mix     = phase[31] ? -int'(AMP_MELODY) : int'(AMP_MELODY);
      phase   = 32'(64'(t) * 64'(BASS_INC[quarter]));
      mix    += phase[31] ? -int'(AMP_BASS) : int'(AMP_BASS);
      if ((t % EIGHTH_SAMPLES) < HAT_WINDOW) begin
        r    = int'((t * HAT_STEP) % HAT_MOD);
        mix += ((2 * r - int'(HAT_MOD)) * int'(AMP_HAT)) / int'(HAT_MOD);
      end
      clip = int'(CLIP_LEVEL);
      if (mix > clip) mix = clip;
      if (mix < -clip) mix = -clip;
      return 16'((mix * int'(volume)) / 256);
    endfunction

    function void note_request(logic [6:0] count);
      int unsigned n, t;
      pcm_beat_t   beat;
      if (!enabled || count == 0) return;
      n = (count > BURST_LIMIT) ? BURST_LIMIT : count;
      for (int unsigned i = 0; i < n; i++) begin
        t = sample_time + i;
        if (t >= WRAP_SAMPLES) t -= WRAP_SAMPLES;
        beat.pcm_sample = synth(t);
        beat.last       = (i + 1 == n);
        expected_q.push_back(beat);
      end
      sample_time = (sample_time + n) % WRAP_SAMPLES;
    endfunction

    function void check_sample(logic signed [15:0] pcm_sample, logic last);
      pcm_beat_t beat;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected transfer, pcm_sample %0d last %0b", $time, pcm_sample, last);
        errors++;
        return;
      end
      beat = expected_q.pop_front();
      if (pcm_sample !== beat.pcm_sample) begin
        $display("%0t: pcm_sample expected %0d actual %0d", $time, beat.pcm_sample, pcm_sample);
        errors++;
      end
      if (last !== beat.last) begin
        $display("%0t: last expected %0b actual %0b", $time, beat.last, last);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [0:0] cfg_idx_i;
  logic [8:0] cfg_wdata_i;
  bit         idling_on;
  int         stall_left;
  int         cycle_count;

  pcm_scoreboard scoreboard;

  swps_req_if req_bus ();
  swps_pcm_if pcm_bus ();

  square_wave_pattern_synth dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_bus),
    .pcm_o      (pcm_bus),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("square_wave_pattern_synth: mismatch");
      $finish;
    end
  end

  // sample sink with random stall bursts
  always @(posedge clk_i) begin
    if (rst_ni && pcm_bus.valid && pcm_bus.ready)
      scoreboard.check_sample(pcm_bus.pcm_sample, pcm_bus.last);
    if (stall_left > 0) begin
      stall_left    <= stall_left - 1;
      pcm_bus.ready <= 1'b0;
    end else if (idling_on && $urandom_range(0, 4) == 0) begin
      stall_left    <= $urandom_range(0, 6);
      pcm_bus.ready <= 1'b0;
    end else begin
      pcm_bus.ready <= 1'b1;
    end
  end

  function automatic logic [6:0] rand_count();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) return 7'($urandom_range(65, 127));
    if (pick < 55) return 7'(BURST_LIMIT);
    if (pick < 60) return 7'd0;
    if (pick < 64) return 7'd1;
    return 7'($urandom_range(1, 63));
  endfunction

  task automatic send_request(input logic [6:0] count);
    int gap;
    gap = (idling_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : 0;
    if (gap > 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_bus.valid        <= 1'b1;
    req_bus.sample_count <= count;
    do @(posedge clk_i); while (!req_bus.ready);
    scoreboard.note_request(count);
  endtask

  task automatic drain(input int settle);
    req_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (scoreboard.pending() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic cfg_write(input reg_idx_e idx, input logic [8:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    scoreboard.configure(idx, data);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    logic [8:0] vol;
    rst_ni               = 1'b0;
    cfg_we_i             = 1'b0;
    cfg_idx_i            = REG_VOLUME;
    cfg_wdata_i          = '0;
    req_bus.valid        = 1'b0;
    req_bus.sample_count = '0;
    pcm_bus.ready        = 1'b0;
    idling_on            = 1'b0;
    stall_left           = 0;
    cycle_count          = 0;
    scoreboard           = new();

    repeat (7) @(posedge clk_i);
    rst_ni    <= 1'b1;
    idling_on <= 1'b1;
    @(posedge clk_i);

    // disabled after reset: requests are dropped and time holds
    send_request(7'd5);
    send_request(7'd127);
    drain(SETTLE_CYCLES);
    cfg_write(REG_ENABLE, 9'd1);
    send_request(7'd1);
    send_request(7'd0);
    send_request(7'd64);
    send_request(7'd65);
    send_request(7'd127);
    send_request(7'd2);
    send_request(7'd3);
    drain(SETTLE_CYCLES);
    cfg_write(REG_VOLUME, 9'd0);
    send_request(7'd10);
    drain(SETTLE_CYCLES);
    cfg_write(REG_VOLUME, 9'd256);
    send_request(7'd20);
    drain(SETTLE_CYCLES);
    cfg_write(REG_VOLUME, 9'd511);
    send_request(7'd8);
    drain(SETTLE_CYCLES);
    cfg_write(REG_VOLUME, 9'd257);
    send_request(7'd4);
    drain(SETTLE_CYCLES);
    cfg_write(REG_VOLUME, 9'd1);
    send_request(7'd16);
    drain(SETTLE_CYCLES);
    cfg_write(REG_ENABLE, 9'd0);
    send_request(7'd30);
    drain(SETTLE_CYCLES);
    cfg_write(REG_ENABLE, 9'd1);

    for (int ph = 0; ph < 6; ph++) begin
      drain(SETTLE_CYCLES);
      case (ph)
        0: vol = 9'd256;
        1: vol = 9'($urandom_range(0, 511));
        2: vol = 9'd1;
        3: vol = 9'($urandom_range(257, 511));
        4: vol = 9'($urandom_range(0, 255));
        default: vol = VOL_RESET;
      endcase
      // final part of the run goes without idling
      if (ph == 4) idling_on <= 1'b0;
      cfg_write(REG_VOLUME, vol);
      if (ph == 2) begin
        cfg_write(REG_ENABLE, 9'd0);
        repeat (5) send_request(rand_count());
        drain(SETTLE_CYCLES);
        cfg_write(REG_ENABLE, 9'd1);
      end
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (k == PHASE_ITEMS / 2 || $urandom_range(0, 39) == 0) drain(0);
        send_request(rand_count());
      end
    end

    drain(SETTLE_CYCLES);
    if (scoreboard.errors == 0 && scoreboard.pending() == 0) begin
      $display("square_wave_pattern_synth: match");
    end else begin
      $display("square_wave_pattern_synth: mismatch");
    end
    $finish;
  end
endmodule

### filelist.f
+incdir+rtl/core
rtl/core/swps_pkg.sv
rtl/core/swps_req_if.sv
rtl/core/swps_pcm_if.sv
rtl/core/swps_mul.sv
rtl/core/square_wave_pattern_synth.sv
tb/sv/testbench.sv
